// ----- rtl/state_vector_gate_apply_macros.svh -----
// Assertion macros for the state vector gate block.
// Used by the checker; needs clk_i and rst_ni in the including scope.
`ifndef STATE_VECTOR_GATE_APPLY_MACROS_SVH
`define STATE_VECTOR_GATE_APPLY_MACROS_SVH

// Generic form with explicit clock and reset.
`define SVGA_ASSERT_CR(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
    else $error("svga assertion failed");

// Short form on the block clock and reset.
`define SVGA_ASSERT(lbl, prop) \
  `SVGA_ASSERT_CR(lbl, clk_i, rst_ni, prop)

`endif

// ----- rtl/svga_pkg.sv -----
// Shared types and codes for the state vector gate block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package svga_pkg;

  localparam logic [1:0] KIND_MAT_WR = 2'd0;
  localparam logic [1:0] KIND_AMP_WR = 2'd1;
  localparam logic [1:0] KIND_APPLY  = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_TGT = 2'd1;
  localparam logic [1:0] ST_BAD_IDX = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         row;
    logic [2:0]         col;
    logic [9:0]         index;
    logic signed [15:0] value_re;
    logic signed [15:0] value_im;
    logic [1:0]         target_count;
    logic [3:0]         target_0;
    logic [3:0]         target_1;
    logic [3:0]         target_2;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] amp_re;
    logic signed [15:0] amp_im;
    logic [1:0]         status;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic issue;
    logic mul;
    logic acc;
    logic rnd;
    logic wb;
    logic base_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic imm_done;
    logic is_read;
    logic skip;
    logic k_last;
    logic j_last;
    logic base_last;
  } dp_stat_t;

endpackage

// ----- rtl/state_vector_gate_apply.sv -----
// Matrix and amplitude writes answer in the cycle after the transfer; reads pass the read-wait
// state before the result is registered. Apply walks every base index, skipping bases with a
// target bit set, and for each of the 2^(q-n) groups with d = 2^n runs d*d complex products
// from one shared complex MAC on registered memory reads; one item is in work at a time.
// Reset clears the sequencer, output valid and qubit count (10); stores are not cleared.
`timescale 1ns / 1ps
module state_vector_gate_apply #(
  parameter int STATE_QUBITS = 10,
  parameter int MAX_TARGETS  = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [3:0]           cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  svga_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output svga_pkg::out_item_t  out_data_o
);
  import svga_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  svga_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  svga_datapath #(
    .STATE_QUBITS (STATE_QUBITS),
    .MAX_TARGETS  (MAX_TARGETS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/svga_ctrl.sv -----
// Sequencer for the state vector gate block.
// Depends on svga_pkg; drives svga_datapath through command signals.
`timescale 1ns / 1ps
module svga_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  svga_pkg::dp_stat_t    stat_i,
  output svga_pkg::ctrl_cmd_t   cmd_o
);
  import svga_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_RD_WAIT = 3'd1;
  localparam logic [2:0] S_A_BASE  = 3'd2;
  localparam logic [2:0] S_A_RD    = 3'd3;
  localparam logic [2:0] S_A_MUL   = 3'd4;
  localparam logic [2:0] S_A_ACC   = 3'd5;
  localparam logic [2:0] S_A_RND   = 3'd6;
  localparam logic [2:0] S_A_WB    = 3'd7;

  logic [2:0] state_q, state_d;
  logic       ovalid_q, ovalid_d;
  logic       accept;

  assign in_ready_o  = (state_q == S_IDLE) && (!ovalid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (stat_i.imm_done) begin
            cmd_o.out_load = 1'b1;
          end else if (stat_i.is_read) begin
            state_d = S_RD_WAIT;
          end else begin
            state_d = S_A_BASE;
          end
        end
      end
      S_RD_WAIT: begin
        cmd_o.out_load = 1'b1;
        state_d = S_IDLE;
      end
      S_A_BASE: begin
        // Bases with any target bit set belong to an earlier group.
        if (stat_i.skip) begin
          if (stat_i.base_last) begin
            cmd_o.out_load = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.base_step = 1'b1;
          end
        end else begin
          state_d = S_A_RD;
        end
      end
      S_A_RD: begin
        cmd_o.issue = 1'b1;
        state_d = S_A_MUL;
      end
      S_A_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_A_ACC;
      end
      S_A_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = stat_i.k_last ? S_A_RND : S_A_RD;
      end
      S_A_RND: begin
        cmd_o.rnd = 1'b1;
        state_d = stat_i.j_last ? S_A_WB : S_A_RD;
      end
      S_A_WB: begin
        cmd_o.wb = 1'b1;
        if (stat_i.k_last) begin
          if (stat_i.base_last) begin
            cmd_o.out_load = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.base_step = 1'b1;
            state_d = S_A_BASE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_o.out_load) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ----- rtl/svga_datapath.sv -----
// Datapath of the state vector gate block: stores, complex MAC, rounding.
// Depends on svga_pkg; steered by svga_ctrl.
`timescale 1ns / 1ps
module svga_datapath #(
  parameter int STATE_QUBITS = 10,
  parameter int MAX_TARGETS  = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [3:0]            cfg_wdata_i,
  input  svga_pkg::in_item_t    in_data_i,
  input  svga_pkg::ctrl_cmd_t   cmd_i,
  output svga_pkg::dp_stat_t    stat_o,
  output svga_pkg::out_item_t   out_data_o
);
  import svga_pkg::*;

  localparam int AW      = STATE_QUBITS;
  localparam int DEPTH   = 1 << AW;
  localparam int TW      = MAX_TARGETS;
  localparam int MAT_DIM = 1 << TW;
  localparam int NT      = (MAX_TARGETS < 3) ? MAX_TARGETS : 3;
  localparam int QW      = $clog2(STATE_QUBITS + 1);
  localparam int Q_RESET = (STATE_QUBITS < 10) ? STATE_QUBITS : 10;
  localparam int ACC_W   = 33 + TW;

  logic [QW-1:0] q_q;

  logic [31:0] amp_mem [DEPTH];
  logic [31:0] mat_mem [MAT_DIM*MAT_DIM];
  logic [31:0] grp_q   [MAT_DIM];

  logic [31:0] amp_rd_q, mat_rd_q;
  logic signed [31:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;

  logic [1:0]    kind_q, stat_q, n_q;
  logic [3:0]    tgt_q [3];
  logic [AW-1:0] mask_q, base_q;
  logic [TW-1:0] j_q, k_q;
  logic          sat_q;
  out_item_t     out_q;

  logic [3:0]    tg [3];
  logic          idx_beyond, mat_beyond, bad_tgt;
  logic [1:0]    status_now;
  logic [AW-1:0] mask_now, size_m1, member;
  logic [TW-1:0] dim_m1;

  // Configuration register, clamped when written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= QW'(Q_RESET);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == 4'd0) begin
        q_q <= QW'(1);
      end else if (32'(cfg_wdata_i) > STATE_QUBITS) begin
        q_q <= QW'(STATE_QUBITS);
      end else begin
        q_q <= QW'(cfg_wdata_i);
      end
    end
  end

  assign size_m1 = AW'((33'd1 << q_q) - 33'd1);
  assign tg[0]   = in_data_i.target_0;
  assign tg[1]   = in_data_i.target_1;
  assign tg[2]   = in_data_i.target_2;

  always_comb begin
    idx_beyond = (32'(in_data_i.index) >> q_q) != 32'd0;
    mat_beyond = (32'(in_data_i.row) >= MAT_DIM) || (32'(in_data_i.col) >= MAT_DIM);
    bad_tgt  = (in_data_i.target_count == 2'd0) ||
               (32'(in_data_i.target_count) > MAX_TARGETS);
    mask_now = '0;
    for (int l = 0; l < 3; l++) begin
      if (l < int'(in_data_i.target_count)) begin
        if (32'(tg[l]) >= 32'(q_q)) bad_tgt = 1'b1;
        for (int m = 0; m < l; m++) begin
          if (tg[m] == tg[l]) bad_tgt = 1'b1;
        end
        mask_now = mask_now | (AW'(1) << tg[l]);
      end
    end
    case (in_data_i.kind)
      KIND_MAT_WR: status_now = mat_beyond ? ST_BAD_IDX : ST_OK;
      KIND_APPLY:  status_now = bad_tgt ? ST_BAD_TGT : ST_OK;
      default:     status_now = idx_beyond ? ST_BAD_IDX : ST_OK;
    endcase
  end

  // Group member k: base with target bit l flipped where bit l of k is set.
  always_comb begin
    member = base_q;
    for (int l = 0; l < NT; l++) begin
      if (k_q[l]) member = member ^ (AW'(1) << tgt_q[l]);
    end
  end

  assign dim_m1 = TW'((32'd1 << n_q) - 32'd1);

  assign stat_o.imm_done  = (in_data_i.kind == KIND_MAT_WR) ||
                            (in_data_i.kind == KIND_AMP_WR) ||
                            ((in_data_i.kind == KIND_APPLY) && bad_tgt);
  assign stat_o.is_read   = (in_data_i.kind == KIND_READ);
  assign stat_o.skip      = (base_q & mask_q) != '0;
  assign stat_o.k_last    = (k_q == dim_m1);
  assign stat_o.j_last    = (j_q == dim_m1);
  assign stat_o.base_last = (base_q == size_m1);

  // Amplitude store: one write and one registered read per cycle.
  logic          amp_we, amp_re;
  logic [AW-1:0] amp_waddr, amp_raddr;
  logic [31:0]   amp_wdata;

  always_comb begin
    amp_we    = cmd_i.wb || (cmd_i.accept && (in_data_i.kind == KIND_AMP_WR) && !idx_beyond);
    amp_waddr = cmd_i.wb ? member : AW'(in_data_i.index);
    amp_wdata = cmd_i.wb ? grp_q[k_q] : {in_data_i.value_re, in_data_i.value_im};
    amp_re    = cmd_i.issue || (cmd_i.accept && (in_data_i.kind == KIND_READ));
    amp_raddr = cmd_i.issue ? member : AW'(in_data_i.index);
  end

  always_ff @(posedge clk_i) begin
    if (amp_we) amp_mem[amp_waddr] <= amp_wdata;
    if (amp_re) amp_rd_q <= amp_mem[amp_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_data_i.kind == KIND_MAT_WR) && !mat_beyond) begin
      mat_mem[{TW'(in_data_i.row), TW'(in_data_i.col)}] <=
        {in_data_i.value_re, in_data_i.value_im};
    end
    if (cmd_i.issue) mat_rd_q <= mat_mem[{j_q, k_q}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_rr_q <= $signed(mat_rd_q[31:16]) * $signed(amp_rd_q[31:16]);
      p_ii_q <= $signed(mat_rd_q[15:0])  * $signed(amp_rd_q[15:0]);
      p_ri_q <= $signed(mat_rd_q[31:16]) * $signed(amp_rd_q[15:0]);
      p_ir_q <= $signed(mat_rd_q[15:0])  * $signed(amp_rd_q[31:16]);
    end
  end

  // Round half up to Q1.14 and saturate to 16 bits.
  logic signed [ACC_W:0] sh_re, sh_im;
  logic signed [15:0]    rs_re, rs_im;
  logic                  sat_re, sat_im;

  always_comb begin
    sh_re = ((ACC_W+1)'(acc_re_q) + (ACC_W+1)'(8192)) >>> 14;
    sh_im = ((ACC_W+1)'(acc_im_q) + (ACC_W+1)'(8192)) >>> 14;
    sat_re = 1'b1;
    sat_im = 1'b1;
    if (sh_re > 32'sd32767) begin
      rs_re = 16'sh7fff;
    end else if (sh_re < -32'sd32768) begin
      rs_re = -16'sh8000;
    end else begin
      rs_re = sh_re[15:0];
      sat_re = 1'b0;
    end
    if (sh_im > 32'sd32767) begin
      rs_im = 16'sh7fff;
    end else if (sh_im < -32'sd32768) begin
      rs_im = -16'sh8000;
    end else begin
      rs_im = sh_im[15:0];
      sat_im = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd) grp_q[j_q] <= {rs_re, rs_im};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept || cmd_i.rnd) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (cmd_i.acc) begin
      acc_re_q <= acc_re_q + ACC_W'(p_rr_q) - ACC_W'(p_ii_q);
      acc_im_q <= acc_im_q + ACC_W'(p_ri_q) + ACC_W'(p_ir_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q   <= in_data_i.kind;
      stat_q   <= status_now;
      n_q      <= in_data_i.target_count;
      tgt_q[0] <= tg[0];
      tgt_q[1] <= tg[1];
      tgt_q[2] <= tg[2];
      mask_q   <= mask_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      j_q    <= '0;
      k_q    <= '0;
      sat_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        base_q <= '0;
        j_q    <= '0;
        k_q    <= '0;
        sat_q  <= 1'b0;
      end else if (cmd_i.base_step) begin
        base_q <= base_q + AW'(1);
        j_q    <= '0;
        k_q    <= '0;
      end else if (cmd_i.acc) begin
        if (!stat_o.k_last) k_q <= k_q + TW'(1);
      end else if (cmd_i.rnd) begin
        k_q   <= '0;
        j_q   <= stat_o.j_last ? '0 : j_q + TW'(1);
        sat_q <= sat_q | sat_re | sat_im;
      end else if (cmd_i.wb) begin
        k_q <= stat_o.k_last ? '0 : k_q + TW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.accept) begin
        out_q.amp_re    <= '0;
        out_q.amp_im    <= '0;
        out_q.status    <= status_now;
        out_q.saturated <= 1'b0;
      end else begin
        if ((kind_q == KIND_READ) && (stat_q == ST_OK)) begin
          out_q.amp_re <= amp_rd_q[31:16];
          out_q.amp_im <= amp_rd_q[15:0];
        end else begin
          out_q.amp_re <= '0;
          out_q.amp_im <= '0;
        end
        out_q.status    <= stat_q;
        out_q.saturated <= sat_q;
      end
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- rtl/svga_checker.sv -----
// Port-level checks for the state vector gate block, bound to the top level.
// Depends on svga_pkg and state_vector_gate_apply_macros.svh.
`timescale 1ns / 1ps
`include "state_vector_gate_apply_macros.svh"
module svga_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input svga_pkg::in_item_t   in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input svga_pkg::out_item_t  out_data_o
);
  import svga_pkg::*;

  // A stalled result keeps its value.
  `SVGA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
  // Writes answer in the cycle after their transfer.
  `SVGA_ASSERT(a_wr_resp, in_valid_i && in_ready_o && (in_data_i.kind == KIND_MAT_WR || in_data_i.kind == KIND_AMP_WR) |=> out_valid_o)
  // A read answers only after its result has passed the read-wait state and the output register.
  `SVGA_ASSERT(a_rd_resp, in_valid_i && in_ready_o && in_data_i.kind == KIND_READ |=> !out_valid_o ##1 out_valid_o)
  // Saturation only comes with a good apply, which returns no amplitude.
  `SVGA_ASSERT(a_sat_ok, out_valid_o && out_data_o.saturated |-> out_data_o.status == ST_OK && out_data_o.amp_re == 16'sd0 && out_data_o.amp_im == 16'sd0)
  // A new transfer is only taken while the result slot is empty or drains.
  `SVGA_ASSERT(a_slot_free, in_ready_o && out_valid_o |-> out_ready_i)

endmodule

bind state_vector_gate_apply svga_checker u_svga_checker (.*);
